// ===== rtl/scfp_pkg.sv =====
// package with shared types and constants of the spi command frame parser
package scfp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned DeltaW   = 14;
  localparam int unsigned WheelW   = 7;
  localparam int unsigned CountW   = 3;
  localparam int unsigned StoreLen = 5;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 64;
  localparam int unsigned OutUserW = 2;

  localparam logic [ByteW-1:0]  CMD_FIRST    = 8'hFC;
  localparam logic [ByteW-1:0]  REPLY_ACK    = 8'hFA;
  localparam logic [ByteW-1:0]  REPLY_NONE   = 8'h00;
  localparam logic [CountW-1:0] MOUSE_LAST   = 3'd5;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_LEDQ    = 3'd1,
    MODE_RELEASE = 3'd2,
    MODE_PRESS   = 3'd3,
    MODE_MOUSE   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_PRESS   = 2'd2,
    KIND_MOUSE   = 2'd3
  } kind_t;

  localparam logic [1:0] CMD_LEDQ    = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_PRESS   = 2'd2;
  localparam logic [1:0] CMD_MOUSE   = 2'd3;

endpackage

// ===== rtl/spi_command_frame_parser.sv =====
// spi command frame parser: framing state machine and registered result word
// the result word for an input word is registered and valid in the cycle after acceptance
// throughput: one input word per cycle while the result side keeps taking words
// the single result register parts the two sides; input is taken when it is
// empty or being emptied in the same cycle
// reset (rst, synchronous, active high) closes any frame and empties the result
module spi_command_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // rx_byte [7:0], led_state [15:8]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // reply_byte, key_code, move_x, move_y, move_wheel,
                                 // button_bits, zero fill
  output logic [1:0]  m_tuser    // event_kind
);

  logic [scfp_pkg::ByteW-1:0] rx_byte;
  logic [scfp_pkg::ByteW-1:0] led_state;
  logic                       accept;
  logic                       is_cmd;

  scfp_pkg::mode_t              mode, mode_next;
  logic [scfp_pkg::CountW-1:0]  bytes_held, bytes_held_next;
  logic                         store_we;
  logic [scfp_pkg::ByteW-1:0]   payload_store [scfp_pkg::StoreLen];

  logic [scfp_pkg::ByteW-1:0]   reply_next;
  scfp_pkg::kind_t              kind_next;
  logic [scfp_pkg::ByteW-1:0]   key_next;
  logic [scfp_pkg::DeltaW-1:0]  mx_next, my_next;
  logic [scfp_pkg::WheelW-1:0]  mw_next;
  logic [scfp_pkg::ByteW-1:0]   btn_next;

  logic [scfp_pkg::ByteW-1:0]   reply_byte;
  scfp_pkg::kind_t              event_kind;
  logic [scfp_pkg::ByteW-1:0]   key_code;
  logic signed [scfp_pkg::DeltaW-1:0] move_x, move_y;
  logic signed [scfp_pkg::WheelW-1:0] move_wheel;
  logic [scfp_pkg::ByteW-1:0]   button_bits;

  assign rx_byte   = s_tdata[7:0];
  assign led_state = s_tdata[15:8];
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign is_cmd    = rx_byte >= scfp_pkg::CMD_FIRST;

  // next state
  always_comb begin
    mode_next       = mode;
    bytes_held_next = bytes_held;
    store_we        = 1'b0;
    priority if (mode == scfp_pkg::MODE_LEDQ) begin
      mode_next       = scfp_pkg::MODE_IDLE;
      bytes_held_next = '0;
    end else if (is_cmd) begin
      bytes_held_next = '0;
      unique case (rx_byte[1:0])
        scfp_pkg::CMD_LEDQ:    mode_next = scfp_pkg::MODE_LEDQ;
        scfp_pkg::CMD_RELEASE: mode_next = scfp_pkg::MODE_RELEASE;
        scfp_pkg::CMD_PRESS:   mode_next = scfp_pkg::MODE_PRESS;
        default:               mode_next = scfp_pkg::MODE_MOUSE;
      endcase
    end else if (mode == scfp_pkg::MODE_MOUSE && bytes_held != scfp_pkg::MOUSE_LAST) begin
      store_we        = 1'b1;
      bytes_held_next = bytes_held + 3'd1;
    end else begin
      mode_next       = scfp_pkg::MODE_IDLE;
      bytes_held_next = '0;
    end
  end

  // result word
  always_comb begin
    reply_next = scfp_pkg::REPLY_NONE;
    kind_next  = scfp_pkg::KIND_NONE;
    key_next   = '0;
    mx_next    = '0;
    my_next    = '0;
    mw_next    = '0;
    btn_next   = '0;
    priority if (mode == scfp_pkg::MODE_LEDQ) begin
      reply_next = led_state;
    end else if (is_cmd) begin
      reply_next = scfp_pkg::REPLY_ACK;
    end else if (mode == scfp_pkg::MODE_RELEASE) begin
      kind_next = scfp_pkg::KIND_RELEASE;
      key_next  = rx_byte;
    end else if (mode == scfp_pkg::MODE_PRESS) begin
      kind_next = scfp_pkg::KIND_PRESS;
      key_next  = rx_byte;
    end else if (mode == scfp_pkg::MODE_MOUSE && bytes_held == scfp_pkg::MOUSE_LAST) begin
      kind_next = scfp_pkg::KIND_MOUSE;
      mx_next   = {payload_store[1][6:0], payload_store[0][6:0]};
      my_next   = {payload_store[3][6:0], payload_store[2][6:0]};
      mw_next   = payload_store[4][6:0];
      btn_next  = rx_byte;
    end else begin
      reply_next = scfp_pkg::REPLY_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= scfp_pkg::MODE_IDLE;
      bytes_held <= '0;
    end else if (accept) begin
      mode       <= mode_next;
      bytes_held <= bytes_held_next;
    end
  end

  // mouse payload bytes, the last one is used straight from the input
  always_ff @(posedge clk) begin
    if (accept && store_we) begin
      payload_store[bytes_held] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      reply_byte  <= reply_next;
      event_kind  <= kind_next;
      key_code    <= key_next;
      move_x      <= mx_next;
      move_y      <= my_next;
      move_wheel  <= mw_next;
      button_bits <= btn_next;
    end
  end

  assign m_tdata = {5'd0, button_bits, move_wheel, move_y, move_x, key_code, reply_byte};
  assign m_tuser = event_kind;

  a_mouse_frame_count : assert property (@(posedge clk) disable iff (rst)
    (mode != scfp_pkg::MODE_MOUSE) |-> (bytes_held == '0))
    else $error("payload count left over outside a mouse frame");

  a_cmd_ack : assert property (@(posedge clk) disable iff (rst)
    (accept && is_cmd && mode != scfp_pkg::MODE_LEDQ)
      |=> (m_tvalid && reply_byte == scfp_pkg::REPLY_ACK
           && event_kind == scfp_pkg::KIND_NONE))
    else $error("command word not acknowledged");

  a_event_no_reply : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && event_kind != scfp_pkg::KIND_NONE)
      |-> (reply_byte == scfp_pkg::REPLY_NONE))
    else $error("event word carries a reply");

  a_ledq_closes : assert property (@(posedge clk) disable iff (rst)
    (accept && mode == scfp_pkg::MODE_LEDQ) |=> (mode == scfp_pkg::MODE_IDLE))
    else $error("led query frame not closed");

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench of the spi command frame parser with random stream idling
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_WORDS = 550;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_AT      = 120;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam logic [7:0]  BYTE_LEDQ    = scfp_pkg::CMD_FIRST + 8'(scfp_pkg::CMD_LEDQ);
  localparam logic [7:0]  BYTE_RELEASE = scfp_pkg::CMD_FIRST + 8'(scfp_pkg::CMD_RELEASE);
  localparam logic [7:0]  BYTE_PRESS   = scfp_pkg::CMD_FIRST + 8'(scfp_pkg::CMD_PRESS);
  localparam logic [7:0]  BYTE_MOUSE   = scfp_pkg::CMD_FIRST + 8'(scfp_pkg::CMD_MOUSE);
  localparam logic [7:0]  DATA_MAX     = scfp_pkg::CMD_FIRST - 8'd1;

  typedef struct packed {
    logic [scfp_pkg::ByteW-1:0]  reply;
    scfp_pkg::kind_t             kind;
    logic [scfp_pkg::ByteW-1:0]  key;
    logic [scfp_pkg::DeltaW-1:0] mx;
    logic [scfp_pkg::DeltaW-1:0] my;
    logic [scfp_pkg::WheelW-1:0] wheel;
    logic [scfp_pkg::ByteW-1:0]  buttons;
  } frame_result_t;

  class frame_scoreboard;
    scfp_pkg::mode_t            mode;
    logic [2:0]                 held;
    logic [scfp_pkg::ByteW-1:0] payload [6];
    frame_result_t              expected_q [$];
    int                         errors;

    function new();
      mode   = scfp_pkg::MODE_IDLE;
      held   = '0;
      errors = 0;
      foreach (payload[i]) payload[i] = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(logic [scfp_pkg::ByteW-1:0] rx, logic [scfp_pkg::ByteW-1:0] leds);
      frame_result_t r;
      logic          done;
      r       = '0;
      r.reply = scfp_pkg::REPLY_NONE;
      r.kind  = scfp_pkg::KIND_NONE;
      if (mode == scfp_pkg::MODE_LEDQ) begin
        r.reply = leds;
        mode    = scfp_pkg::MODE_IDLE;
        held    = '0;
      end else if (rx >= scfp_pkg::CMD_FIRST) begin
        r.reply = scfp_pkg::REPLY_ACK;
        held    = '0;
        case (rx[1:0])
          scfp_pkg::CMD_LEDQ:    mode = scfp_pkg::MODE_LEDQ;
          scfp_pkg::CMD_RELEASE: mode = scfp_pkg::MODE_RELEASE;
          scfp_pkg::CMD_PRESS:   mode = scfp_pkg::MODE_PRESS;
          default:               mode = scfp_pkg::MODE_MOUSE;
        endcase
      end else if (mode == scfp_pkg::MODE_RELEASE || mode == scfp_pkg::MODE_PRESS
                   || mode == scfp_pkg::MODE_MOUSE) begin
        if (held < 3'd6) payload[held] = rx;
        held = held + 3'd1;
        done = (mode == scfp_pkg::MODE_MOUSE) ? (held >= 3'd6) : 1'b1;
        if (done) begin
          if (mode == scfp_pkg::MODE_MOUSE) begin
            r.kind    = scfp_pkg::KIND_MOUSE;
            r.mx      = {payload[1][6:0], payload[0][6:0]};
            r.my      = {payload[3][6:0], payload[2][6:0]};
            r.wheel   = payload[4][6:0];
            r.buttons = payload[5];
          end else begin
            r.kind = (mode == scfp_pkg::MODE_RELEASE) ? scfp_pkg::KIND_RELEASE
                                                      : scfp_pkg::KIND_PRESS;
            r.key  = payload[0];
          end
          mode = scfp_pkg::MODE_IDLE;
          held = '0;
        end
      end else begin
        mode = scfp_pkg::MODE_IDLE;
        held = '0;
      end
      expected_q.push_back(r);
    endfunction

    function void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [scfp_pkg::OutDataW-1:0] d,
                               logic [scfp_pkg::OutUserW-1:0] u);
      frame_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, actual %h/%h", $time, d, u);
        return;
      end
      e = expected_q.pop_front();
      check_field("reply_byte", 16'(e.reply), 16'(d[7:0]));
      check_field("event_kind", 16'(e.kind), 16'(u));
      check_field("key_code", 16'(e.key), 16'(d[15:8]));
      check_field("move_x", 16'(e.mx), 16'(d[29:16]));
      check_field("move_y", 16'(e.my), 16'(d[43:30]));
      check_field("move_wheel", 16'(e.wheel), 16'(d[50:44]));
      check_field("button_bits", 16'(e.buttons), 16'(d[58:51]));
      check_field("zero fill", 16'h0000, 16'(d[63:59]));
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [scfp_pkg::InDataW-1:0]  s_tdata = '0;   // rx_byte [7:0], led_state [15:8]
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [scfp_pkg::OutDataW-1:0] m_tdata;        // reply_byte, key_code, move_x, move_y,
                                                 // move_wheel, button_bits, zero fill
  logic [scfp_pkg::OutUserW-1:0] m_tuser;        // event_kind

  frame_scoreboard sb = new();
  int              send_calm = 0;
  int              recv_calm = 0;
  int              words_sent = 0;
  int              words_seen = 0;
  int              cycle_count = 0;

  spi_command_frame_parser uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // random gaps, with zero-gap stretches now and then
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) calm = 20;
    return $urandom_range(0, 9);
  endfunction

  task automatic send_word(input logic [7:0] rx, input logic [7:0] leds);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {leds, rx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(rx, leds);
    words_sent++;
  endtask

  task automatic send_data(input logic [7:0] rx);
    send_word(rx, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap(recv_calm);
      if (words_seen == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.check_result(m_tdata, m_tuser);
      words_seen++;
    end
  end

  initial begin
    int          cmd;
    int          len;
    int          count;
    logic [7:0]  seq [$];
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // data outside a frame
    send_word(8'h00, 8'h00);
    send_word(DATA_MAX, 8'hFF);
    // two led queries, one swallowing a data word and one a command word
    send_word(BYTE_LEDQ, 8'hA5);
    send_word(8'h00, 8'hFF);
    send_word(BYTE_LEDQ, 8'h5A);
    send_word(BYTE_MOUSE, 8'h00);
    // key events at the code extremes
    send_data(BYTE_PRESS);
    send_data(DATA_MAX);
    send_data(BYTE_RELEASE);
    send_data(8'h00);
    // mouse: max positive x, min y, min wheel
    seq = '{BYTE_MOUSE, 8'h7F, 8'h3F, 8'h00, 8'h40, 8'h40, DATA_MAX};
    foreach (seq[i]) send_data(seq[i]);
    // mouse with bit 7 set in the five delta and wheel bytes
    seq = '{BYTE_MOUSE, 8'hFB, 8'hBF, 8'h80, 8'hC0, 8'hBF, 8'h00};
    foreach (seq[i]) send_data(seq[i]);
    // command in mid-frame restarts framing
    seq = '{BYTE_MOUSE, 8'h01, BYTE_PRESS, 8'h05};
    foreach (seq[i]) send_data(seq[i]);

    while (words_sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 9) < 2) begin
        send_data(8'($urandom_range(0, 255)));
      end else begin
        cmd = $urandom_range(0, 3);
        send_data(scfp_pkg::CMD_FIRST + 8'(cmd));
        if (cmd == scfp_pkg::CMD_LEDQ) begin
          send_data(8'($urandom_range(0, 255)));
        end else begin
          len   = (cmd == scfp_pkg::CMD_MOUSE) ? 6 : 1;
          count = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : len;
          repeat (count) send_data(8'($urandom_range(0, DATA_MAX)));
        end
      end
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== spi_command_frame_parser.f =====
rtl/scfp_pkg.sv
rtl/spi_command_frame_parser.sv
tb/sv/tb_top.sv
